// ===== design/hiap_pkg.sv =====
// ----------------------------------------------------------------------------
// hiap_pkg
// Shared types, constants and character helpers for the HTML integer
// attribute parser.
// ----------------------------------------------------------------------------
package hiap_pkg;

	// accumulator, product, configuration and clamp widths
	localparam int MAG_W     = 32;
	localparam int PROD_W    = MAG_W + 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int CLAMP_W   = 31;

	localparam logic [MAG_W-1:0] TWO_POW_31   = 32'h8000_0000;
	localparam logic [MAG_W-1:0] ABOVE_BOUNDS = 32'h8000_0001;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 2'd3;

	// reset value of the clamp high configuration register
	localparam logic [CLAMP_W-1:0] CLAMP_HIGH_RESET = 31'h7FFF_FFFF;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		MODE_SIGNED   = 2'd0,
		MODE_NONNEG   = 2'd1,
		MODE_POSITIVE = 2'd2,
		MODE_CLAMP    = 2'd3
	} range_mode_t;

	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_STOP   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
	} hiap_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               from_text;
	} hiap_result_t;

	// parse state as it stands after the final character of a string
	typedef struct packed {
		logic             negative;
		logic [MAG_W-1:0] magnitude;
		logic             too_big;
		logic             any_digit;
	} hiap_snap_t;

	function automatic logic is_html_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ===== design/html_integer_attribute_parser.sv =====
// ----------------------------------------------------------------------------
// html_integer_attribute_parser
// Parses attribute text, one character per word, by the HTML integer rules
// and gives one range-checked result word per string.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                      | handshake
//  ---------+-----------+------------------------------+-------------------------
//  item     | in        | hiap_item_t (ch,has_char,last)| item_valid / item_ready
//  result   | out       | hiap_result_t                | result_valid / result_ready
//  cfg      | in        | cfg_index, cfg_data          | cfg_valid / cfg_ready
//
// One character word is taken every cycle while item_ready is high. After its
// last word is taken, a string's result passes the input register, then the final
// parse state register, then the result register after the range check.
// Reset clears parse state, pipeline valids and configuration to defaults.
// A stalled result holds its register; earlier stages keep flowing into any
// bubble, and only a full pipe pushes back on item_ready.
// Configuration writes are taken every cycle (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module html_integer_attribute_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  hiap_pkg::hiap_item_t            item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output hiap_pkg::hiap_result_t          result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hiap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hiap_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import hiap_pkg::*;

	// configuration registers
	range_mode_t        range_mode_q;
	logic signed [31:0] fallback_q;
	logic [CLAMP_W-1:0] clamp_low_q;
	logic [CLAMP_W-1:0] clamp_high_q;

	// pipeline
	hiap_item_t   item_s1;
	logic         valid_s1;
	hiap_snap_t   snap_s2;
	logic         valid_s2;
	hiap_snap_t   snap_next;
	hiap_result_t result_next;
	hiap_result_t result_q;
	logic         result_valid_q;

	logic out_free;
	logic s2_free;
	logic s1_go;
	logic s2_go;

	// stage enables
	always_comb begin
		out_free   = !result_valid_q || result_ready;
		s2_free    = !valid_s2 || out_free;
		s2_go      = valid_s2 && out_free;
		s1_go      = valid_s1 && (!item_s1.last || s2_free);
		item_ready = !valid_s1 || s1_go;
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_mode_q <= MODE_SIGNED;
			fallback_q   <= '0;
			clamp_low_q  <= '0;
			clamp_high_q <= CLAMP_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RANGE_MODE: range_mode_q <= range_mode_t'(cfg_data[1:0]);
				CFG_FALLBACK:   fallback_q   <= $signed(cfg_data[31:0]);
				CFG_CLAMP_LOW:  clamp_low_q  <= cfg_data[CLAMP_W-1:0];
				CFG_CLAMP_HIGH: clamp_high_q <= cfg_data[CLAMP_W-1:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// parse state update
	hiap_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.item   (item_s1),
		.snap   (snap_next)
	);

	// final parse state register, loaded by a last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_go && item_s1.last) begin
			snap_s2 <= snap_next;
		end
	end

	// range check
	hiap_check u_check (
		.range_mode     (range_mode_q),
		.fallback_value (fallback_q),
		.clamp_low      (clamp_low_q),
		.clamp_high     (clamp_high_q),
		.snap           (snap_s2),
		.result         (result_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s2_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			result_q <= result_next;
		end
	end

endmodule

// ===== design/hiap_parse.sv =====
// ----------------------------------------------------------------------------
// hiap_parse
// Character-by-character parse state: whitespace skip, sign, decimal
// accumulation with a sticky overflow flag. Clears after the last character.
// ----------------------------------------------------------------------------
module hiap_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  hiap_pkg::hiap_item_t item,
	output hiap_pkg::hiap_snap_t snap
);
	import hiap_pkg::*;

	phase_t           phase_q, phase_d;
	logic             negative_q, negative_d;
	logic [MAG_W-1:0] magnitude_q, magnitude_d;
	logic             too_big_q, too_big_d;
	logic             any_digit_q, any_digit_d;

	logic [PROD_W-1:0] prod;
	logic              overflow;
	logic              digit;

	// times ten plus digit, as two shifts and adds
	always_comb begin
		prod = (PROD_W'(magnitude_q) << 3) + (PROD_W'(magnitude_q) << 1) +
			PROD_W'(item.ch[3:0]);
		overflow = too_big_q || (prod > PROD_W'(TWO_POW_31));
		digit = is_digit(item.ch);
	end

	// next parse state for the current character
	always_comb begin
		phase_d     = phase_q;
		negative_d  = negative_q;
		magnitude_d = magnitude_q;
		too_big_d   = too_big_q;
		any_digit_d = any_digit_q;
		if (item.has_char) begin
			unique case (phase_q)
				PH_SPACE: begin
					if (is_html_space(item.ch)) begin
						phase_d = PH_SPACE;
					end else if (item.ch == CH_MINUS) begin
						negative_d = 1'b1;
						phase_d    = PH_SIGN;
					end else if (item.ch == CH_PLUS) begin
						phase_d = PH_SIGN;
					end else if (digit) begin
						phase_d     = PH_DIGITS;
						any_digit_d = 1'b1;
						too_big_d   = overflow;
						if (!overflow) magnitude_d = prod[MAG_W-1:0];
					end else begin
						phase_d = PH_STOP;
					end
				end
				PH_SIGN, PH_DIGITS: begin
					if (digit) begin
						phase_d     = PH_DIGITS;
						any_digit_d = 1'b1;
						too_big_d   = overflow;
						if (!overflow) magnitude_d = prod[MAG_W-1:0];
					end else begin
						phase_d = PH_STOP;
					end
				end
				PH_STOP: begin
					phase_d = PH_STOP;
				end
			endcase
		end
		snap.negative  = negative_d;
		snap.magnitude = magnitude_d;
		snap.too_big   = too_big_d;
		snap.any_digit = any_digit_d;
	end

	// state register, cleared after each finished string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SPACE;
			negative_q  <= 1'b0;
			magnitude_q <= '0;
			too_big_q   <= 1'b0;
			any_digit_q <= 1'b0;
		end else if (go) begin
			if (item.last) begin
				phase_q     <= PH_SPACE;
				negative_q  <= 1'b0;
				magnitude_q <= '0;
				too_big_q   <= 1'b0;
				any_digit_q <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				negative_q  <= negative_d;
				magnitude_q <= magnitude_d;
				too_big_q   <= too_big_d;
				any_digit_q <= any_digit_d;
			end
		end
	end

endmodule

// ===== design/hiap_check.sv =====
// ----------------------------------------------------------------------------
// hiap_check
// Range check of a finished parse under the configured mode; picks the
// parsed value, the clamped value or the fallback.
// ----------------------------------------------------------------------------
module hiap_check (
	input  hiap_pkg::range_mode_t            range_mode,
	input  logic signed [31:0]               fallback_value,
	input  logic [hiap_pkg::CLAMP_W-1:0]     clamp_low,
	input  logic [hiap_pkg::CLAMP_W-1:0]     clamp_high,
	input  hiap_pkg::hiap_snap_t             snap,
	output hiap_pkg::hiap_result_t           result
);
	import hiap_pkg::*;

	logic             neg_nonzero;
	logic             ok;
	logic [MAG_W-1:0] v;
	logic [MAG_W-1:0] x_raw;
	logic [MAG_W-1:0] x_low;
	logic [MAG_W-1:0] lo;
	logic [MAG_W-1:0] hi;

	// clamp path: raise to the low bound, then lower to the high bound
	always_comb begin
		lo    = {1'b0, clamp_low};
		hi    = {1'b0, clamp_high};
		x_raw = snap.too_big ? ABOVE_BOUNDS : snap.magnitude;
		x_low = (x_raw < lo) ? lo : x_raw;
	end

	// mode check
	always_comb begin
		neg_nonzero = snap.negative && (snap.too_big || (snap.magnitude != '0));
		ok = 1'b0;
		v  = snap.magnitude;
		if (snap.any_digit) begin
			unique case (range_mode)
				MODE_SIGNED: begin
					if (!snap.too_big) begin
						if (snap.negative) begin
							ok = 1'b1;
							v  = MAG_W'(0) - snap.magnitude;
						end else begin
							ok = !snap.magnitude[MAG_W-1];
						end
					end
				end
				MODE_NONNEG, MODE_POSITIVE: begin
					ok = !neg_nonzero && !snap.too_big && !snap.magnitude[MAG_W-1] &&
						((range_mode == MODE_NONNEG) || (snap.magnitude != '0));
				end
				MODE_CLAMP: begin
					ok = !neg_nonzero;
					v  = (x_low > hi) ? hi : x_low;
				end
			endcase
		end
		result.result_value = ok ? $signed(v) : fallback_value;
		result.from_text    = ok;
	end

endmodule
